>>> rtl/srit_pkg.sv
`default_nettype none

package srit_pkg;

   // Codes of the action field of a request beat.
   typedef logic [1:0] action_type;
   localparam action_type ACT_ADD    = 2'd0;
   localparam action_type ACT_APPEND = 2'd1;
   localparam action_type ACT_CLEAR  = 2'd2;
   localparam action_type ACT_READ   = 2'd3;

   // Codes of the status field of a response beat.
   typedef logic [1:0] status_type;
   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_DUP   = 2'd1;
   localparam status_type ST_FULL  = 2'd2;
   localparam status_type ST_INDEX = 2'd3;

   // Field order gives the compound key order: score, then lines, then level.
   typedef struct packed {
      logic [31:0] score;
      logic [15:0] lines;
      logic [15:0] level;
   } record_type;

endpackage

`default_nettype wire

>>> rtl/sorted_record_insert_table_unit.sv
`default_nettype none

// Channel | Direction | Handshake             | Payload
// req_    | in        | req_valid / req_stall | action, rec_score/lines/level, read_index
// rsp_    | out       | rsp_valid / rsp_stall | status, slot, entry_count, entry_*
//
// One request is in work at a time; the table lives in one memory with a
// single read and a single write port, read data registered. An add compares
// stored entries one per cycle and then moves entries down (read, then write);
// a rejected add moves none. While a response is stalled, the next request is
// still accepted and waits to finish. Reset empties the table at once.
module sorted_record_insert_table_unit #(
   parameter int CAPACITY = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire srit_pkg::action_type req_action,
   input  wire logic [31:0]         req_rec_score,
   input  wire logic [15:0]         req_rec_lines,
   input  wire logic [15:0]         req_rec_level,
   input  wire logic [3:0]          req_read_index,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output srit_pkg::status_type     rsp_status,
   output logic [3:0]               rsp_slot,
   output logic [4:0]               rsp_entry_count,
   output logic [31:0]              rsp_entry_score,
   output logic [15:0]              rsp_entry_lines,
   output logic [15:0]              rsp_entry_level
);
   import srit_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);
   localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
   localparam logic [CW-1:0] LAST_C = CW'(CAPACITY - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_MOVE,
      S_READ,
      S_DONE
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [CW-1:0] idx_ff, idx_in;
   record_type    rec_ff, rec_in;
   status_type    res_status_ff, res_status_in;
   logic [3:0]    res_slot_ff, res_slot_in;
   record_type    res_entry_ff, res_entry_in;
   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff, rsp_status_in;
   logic [3:0]    rsp_slot_ff, rsp_slot_in;
   logic [4:0]    rsp_count_ff, rsp_count_in;
   record_type    rsp_entry_ff, rsp_entry_in;

   record_type    mem [CAPACITY];
   record_type    rd_data_ff;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   record_type    wr_data;

   record_type    req_rec;
   logic [CW+3:0] req_idx_ext;
   logic [CW+3:0] count_ext;
   logic [CW-1:0] pos_next;
   logic [CW-1:0] idx_prev;
   logic [63:0]   stored_key;
   logic [63:0]   new_key;
   logic          rsp_free;

   function automatic logic [3:0] slot_of(input logic [CW-1:0] v);
      logic [CW+3:0] ext;
      ext = {4'b0, v};
      return ext[3:0];
   endfunction

   function automatic logic [4:0] count_of(input logic [CW-1:0] v);
      logic [CW+4:0] ext;
      ext = {5'b0, v};
      return ext[4:0];
   endfunction

   assign req_rec     = '{score: req_rec_score, lines: req_rec_lines, level: req_rec_level};
   assign req_idx_ext = {{CW{1'b0}}, req_read_index};
   assign count_ext   = {4'b0, count_ff};
   assign pos_next    = pos_ff + 1'b1;
   assign idx_prev    = idx_ff - 1'b1;
   assign stored_key  = {rd_data_ff.score, rd_data_ff.lines, rd_data_ff.level};
   assign new_key     = {rec_ff.score, rec_ff.lines, rec_ff.level};
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = (state_ff != S_IDLE);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      idx_in        = idx_ff;
      rec_in        = rec_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_entry_in  = res_entry_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_entry_in  = rsp_entry_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = rec_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               rec_in        = req_rec;
               res_status_in = ST_OK;
               res_slot_in   = '0;
               res_entry_in  = '0;
               state_in      = S_DONE;
               case (req_action)
                  ACT_ADD: begin
                     pos_in = '0;
                     if (count_ff == '0) begin
                        idx_in   = '0;
                        state_in = S_SHIFT;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        state_in = S_SCAN;
                     end
                  end
                  ACT_APPEND: begin
                     if (count_ff == CAP_C) begin
                        res_status_in = ST_FULL;
                     end else begin
                        wr_en       = 1'b1;
                        wr_addr     = count_ff[AW-1:0];
                        wr_data     = req_rec;
                        res_slot_in = slot_of(count_ff);
                        count_in    = count_ff + 1'b1;
                     end
                  end
                  ACT_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     res_slot_in = req_read_index;
                     if (req_idx_ext >= count_ext) begin
                        res_status_in = ST_INDEX;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = req_idx_ext[AW-1:0];
                        state_in = S_READ;
                     end
                  end
               endcase
            end
         end

         // One stored entry is compared per cycle while the next is read.
         S_SCAN: begin
            if (stored_key > new_key) begin
               if (pos_next == count_ff) begin
                  pos_in = count_ff;
                  if (count_ff == CAP_C) begin
                     res_status_in = ST_FULL;
                     res_slot_in   = '0;
                     state_in      = S_DONE;
                  end else begin
                     idx_in   = count_ff;
                     state_in = S_SHIFT;
                  end
               end else begin
                  pos_in  = pos_next;
                  rd_en   = 1'b1;
                  rd_addr = pos_next[AW-1:0];
               end
            end else if (stored_key == new_key) begin
               res_status_in = ST_DUP;
               res_slot_in   = slot_of(pos_ff);
               state_in      = S_DONE;
            end else begin
               // On a full table the last entry is dropped.
               idx_in   = (count_ff == CAP_C) ? LAST_C : count_ff;
               state_in = S_SHIFT;
            end
         end

         // Entries from the tail down to the insert point move one slot down.
         S_SHIFT: begin
            if (idx_ff > pos_ff) begin
               rd_en    = 1'b1;
               rd_addr  = idx_prev[AW-1:0];
               state_in = S_MOVE;
            end else begin
               wr_en       = 1'b1;
               wr_addr     = pos_ff[AW-1:0];
               wr_data     = rec_ff;
               res_slot_in = slot_of(pos_ff);
               if (count_ff != CAP_C) begin
                  count_in = count_ff + 1'b1;
               end
               state_in = S_DONE;
            end
         end

         S_MOVE: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff[AW-1:0];
            wr_data  = rd_data_ff;
            idx_in   = idx_prev;
            state_in = S_SHIFT;
         end

         S_READ: begin
            res_entry_in = rd_data_ff;
            state_in     = S_DONE;
         end

         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_count_in  = count_of(count_ff);
               rsp_entry_in  = res_entry_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff        <= pos_in;
      idx_ff        <= idx_in;
      rec_ff        <= rec_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_entry_ff  <= res_entry_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_entry_ff  <= rsp_entry_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_entry_score = rsp_entry_ff.score;
   assign rsp_entry_lines = rsp_entry_ff.lines;
   assign rsp_entry_level = rsp_entry_ff.level;

endmodule

`default_nettype wire

>>> rtl/srit_checker.sv
`default_nettype none

module srit_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_stall,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire srit_pkg::status_type rsp_status,
   input wire logic [3:0]           rsp_slot,
   input wire logic [4:0]           rsp_entry_count,
   input wire logic [31:0]          rsp_entry_score,
   input wire logic [15:0]          rsp_entry_lines,
   input wire logic [15:0]          rsp_entry_level
);
   import srit_pkg::*;

   // No response beat is left over from before a reset, and the input is open.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("response valid or input stalled right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_slot)
         && $stable(rsp_entry_count) && $stable(rsp_entry_score)
         && $stable(rsp_entry_lines) && $stable(rsp_entry_level))
      else $error("stalled response beat changed");

   // Only a successful read carries entry data.
   a_entry_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_entry_score != '0 || rsp_entry_lines != '0
         || rsp_entry_level != '0) |-> rsp_status == ST_OK)
      else $error("entry data on a failed response");

   a_full_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_slot == 4'd0)
      else $error("full rejection with nonzero slot");

endmodule

bind sorted_record_insert_table_unit srit_checker u_srit_checker (.*);

`default_nettype wire
